// ===== rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared widths, byte codes, scan state type and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

  localparam int LINE_MAX = 4096;
  localparam int OFF_W    = $clog2(LINE_MAX + 2);
  localparam int ROW_W    = 32;

  localparam logic [OFF_W-1:0] LINE_MAX_OFF = OFF_W'(LINE_MAX);
  localparam logic [OFF_W-1:0] COL_MAX      = OFF_W'(LINE_MAX + 1);

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef enum logic [5:0] {
    ST_BEGIN   = 6'b000001,
    ST_CONTENT = 6'b000010,
    ST_QUOTE   = 6'b000100,
    ST_AFTER   = 6'b001000,
    ST_ESC_Q   = 6'b010000,
    ST_ESC_O   = 6'b100000
  } scan_state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [OFF_W-1:0] column;
    logic [OFF_W-1:0] field_start;
    logic [OFF_W-1:0] field_end;
    logic             last_in_line;
    logic             too_long;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/cft_if.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer channels
// Valid/ready channels for line bytes in and field items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface cft_out_if;
  logic                      valid;
  logic                      ready;
  logic [cft_pkg::ROW_W-1:0] row;
  logic [cft_pkg::OFF_W-1:0] column;
  logic [cft_pkg::OFF_W-1:0] field_start;
  logic [cft_pkg::OFF_W-1:0] field_end;
  logic                      last_in_line;
  logic                      too_long;

  modport source (output valid, output row, output column, output field_start,
                  output field_end, output last_in_line, output too_long,
                  input ready);
  modport sink (input valid, input row, input column, input field_start,
                input field_end, input last_in_line, input too_long,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/cft_scan.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer scanner
// Holds the per-line scan state and decides one byte or line end per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  input  logic                line_end_i,
  output logic                emit_o,
  output cft_pkg::res_t       res_o
);
  import cft_pkg::*;

  scan_state_e      state_q, state_d, state_n;
  logic [OFF_W-1:0] pos_q, pos_d;
  logic [OFF_W-1:0] start_q, start_d, start_n;
  logic [OFF_W-1:0] end_q, end_d, end_n;
  logic [OFF_W-1:0] col_q, col_d, col_inc;
  logic [ROW_W-1:0] row_q, row_d;
  logic             tail_q, tail_d, tail_n;
  logic             ovf_q, ovf_d, ovf_n;
  logic [OFF_W-1:0] p1;
  logic             blank;
  logic             emit;
  logic             last;

  assign blank   = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
  assign p1      = (pos_q == LINE_MAX_OFF) ? LINE_MAX_OFF : pos_q + OFF_W'(1);
  assign col_inc = (col_q == COL_MAX) ? col_q : col_q + OFF_W'(1);

  always_comb begin
    state_n = state_q;
    start_n = start_q;
    end_n   = end_q;
    tail_n  = tail_q;
    ovf_n   = ovf_q;
    emit    = 1'b0;
    last    = 1'b0;
    if (line_end_i) begin
      last = 1'b1;
      unique case (state_q)
        ST_CONTENT, ST_AFTER: emit = 1'b1;
        ST_QUOTE, ST_ESC_Q, ST_ESC_O: emit = 1'b0;
        default: begin
          if (tail_q) begin
            start_n = pos_q;
            end_n   = pos_q;
            emit    = 1'b1;
          end
        end
      endcase
    end else begin
      if (pos_q == LINE_MAX_OFF) begin
        ovf_n = 1'b1;
      end
      unique case (state_q)
        ST_CONTENT: begin
          if (ch_i == CH_COMMA) begin
            tail_n  = 1'b1;
            emit    = 1'b1;
            state_n = ST_BEGIN;
          end else if (ch_i == CH_BSLASH) begin
            state_n = ST_ESC_O;
          end else if (!blank) begin
            end_n = p1;
          end
        end
        ST_QUOTE: begin
          if (ch_i == CH_BSLASH) begin
            state_n = ST_ESC_Q;
          end else if (ch_i == CH_QUOTE) begin
            end_n   = pos_q;
            state_n = ST_AFTER;
          end
        end
        ST_AFTER: begin
          if (ch_i == CH_COMMA) begin
            tail_n  = 1'b1;
            emit    = 1'b1;
            state_n = ST_BEGIN;
          end
        end
        ST_ESC_Q: state_n = ST_QUOTE;
        ST_ESC_O: state_n = ST_CONTENT;
        default: begin
          if (ch_i == CH_COMMA) begin
            start_n = pos_q;
            end_n   = pos_q;
            tail_n  = 1'b1;
            emit    = 1'b1;
            state_n = ST_BEGIN;
          end else if (blank) begin
            state_n = ST_BEGIN;
          end else if (ch_i == CH_QUOTE) begin
            start_n = p1;
            end_n   = p1;
            state_n = ST_QUOTE;
          end else begin
            start_n = pos_q;
            end_n   = p1;
            state_n = ST_CONTENT;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_n;
    start_d = start_n;
    end_d   = end_n;
    tail_d  = tail_n;
    ovf_d   = ovf_n;
    pos_d   = p1;
    col_d   = emit ? col_inc : col_q;
    row_d   = row_q;
    if (line_end_i) begin
      state_d = ST_BEGIN;
      start_d = '0;
      end_d   = '0;
      tail_d  = 1'b0;
      ovf_d   = 1'b0;
      pos_d   = '0;
      col_d   = '0;
      row_d   = (row_q == '1) ? ROW_W'(1) : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BEGIN;
      pos_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      col_q   <= '0;
      row_q   <= ROW_W'(1);
      tail_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      end_q   <= end_d;
      col_q   <= col_d;
      row_q   <= row_d;
      tail_q  <= tail_d;
      ovf_q   <= ovf_d;
    end
  end

  assign emit_o             = emit;
  assign res_o.row          = row_q;
  assign res_o.column       = col_inc;
  assign res_o.field_start  = start_n;
  assign res_o.field_end    = end_n;
  assign res_o.last_in_line = last;
  assign res_o.too_long     = ovf_n;

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LINE_MAX_OFF && start_q <= LINE_MAX_OFF && end_q <= LINE_MAX_OFF)
    else $error("offset beyond line maximum");

  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && line_end_i |=> pos_q == '0 && col_q == '0 && !tail_q && !ovf_q)
    else $error("per-line state not cleared at line end");

  a_col_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_MAX)
    else $error("column count beyond saturation");

  a_row_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != '0)
    else $error("row number reached zero");

endmodule

`default_nettype wire

// ===== rtl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a stream of line bytes into field items with row, column and offsets.
// ----------------------------------------------------------------------------
// Usage: in_i carries one line byte per item, or a line-end marker when
// line_end is set. out_o carries one field item for each field closed by a
// comma or by the line end; many input items produce no output item.
// An accepted input item is held in an input register while the scanner
// decides it, and any field item lands in the output register, so a field
// item passes through both registers before it appears on out_o. One input
// item is taken every cycle as long as the output register is empty or is
// drained in the same cycle.
// When the receiver stalls with a field item pending, input items that close
// no field still pass; an item that would close a field waits in the input
// register, and in_i.ready then falls until out_o.ready returns.
// Reset clears the valid flags of both registers and the scan state; the
// row number restarts at one.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer (
  input  logic  clk_i,
  input  logic  rst_ni,
  cft_in_if.sink    in_i,
  cft_out_if.source out_o
);
  import cft_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_le_q;
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       scan_res;
  logic       scan_emit;
  logic       s1_adv;
  logic       out_free;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!scan_emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q <= in_i.ch;
      s1_le_q <= in_i.line_end;
    end
  end

  cft_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_adv),
    .ch_i       (s1_ch_q),
    .line_end_i (s1_le_q),
    .emit_o     (scan_emit),
    .res_o      (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && scan_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && scan_emit) begin
      out_res_q <= scan_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.row          = out_res_q.row;
  assign out_o.column       = out_res_q.column;
  assign out_o.field_start  = out_res_q.field_start;
  assign out_o.field_end    = out_res_q.field_end;
  assign out_o.last_in_line = out_res_q.last_in_line;
  assign out_o.too_long     = out_res_q.too_long;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && scan_emit |-> out_free)
    else $error("pending field item overwritten");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_ch_q) && $stable(s1_le_q))
    else $error("blocked input item lost");

  a_ready_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && scan_emit && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while blocked on the output");

endmodule

`default_nettype wire

// ===== tb/cft_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field tokenizer checker
// Watches both channels of the tokenizer. Every accepted line byte or line
// end is run through a cycle-free model of the field scanner, and any field
// it closes is queued. Every accepted field item is compared field by field
// with the oldest queued field.
// ----------------------------------------------------------------------------

module cft_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cft_in_if           in_mon,
  cft_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import cft_pkg::*;

  scan_state_e      scan_st;
  logic [OFF_W-1:0] pos_cnt;
  logic [OFF_W-1:0] start_mark;
  logic [OFF_W-1:0] end_mark;
  logic [OFF_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             empty_tail;
  logic             overflow_seen;

  res_t             expected_fields[$];
  int unsigned      mismatches  = 0;
  int unsigned      outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  task automatic restart_line();
    scan_st       = ST_BEGIN;
    pos_cnt       = '0;
    start_mark    = '0;
    end_mark      = '0;
    col_cnt       = '0;
    empty_tail    = 1'b0;
    overflow_seen = 1'b0;
  endtask

  task automatic close_field(input logic last);
    logic [OFF_W:0] next_col;
    res_t           fld;
    next_col = {1'b0, col_cnt} + 1'b1;
    if (next_col > {1'b0, COL_MAX}) begin
      next_col = {1'b0, COL_MAX};
    end
    fld.row          = row_cnt;
    fld.column       = next_col[OFF_W-1:0];
    fld.field_start  = start_mark;
    fld.field_end    = end_mark;
    fld.last_in_line = last;
    fld.too_long     = overflow_seen;
    expected_fields.push_back(fld);
    col_cnt = next_col[OFF_W-1:0];
  endtask

  task automatic scan_item(input logic [7:0] c, input logic eol);
    logic [OFF_W-1:0] p;
    logic [OFF_W-1:0] p1;
    logic [OFF_W:0]   nx;
    if (eol) begin
      if (scan_st == ST_CONTENT || scan_st == ST_AFTER) begin
        close_field(1'b1);
      end else if (scan_st == ST_BEGIN && empty_tail) begin
        start_mark = (pos_cnt > LINE_MAX_OFF) ? LINE_MAX_OFF : pos_cnt;
        end_mark   = start_mark;
        close_field(1'b1);
      end
      restart_line();
      row_cnt = (row_cnt == '1) ? ROW_W'(1) : row_cnt + 1'b1;
    end else begin
      p = pos_cnt;
      if (pos_cnt >= LINE_MAX_OFF) begin
        p             = LINE_MAX_OFF;
        overflow_seen = 1'b1;
      end
      nx = {1'b0, p} + 1'b1;
      p1 = (nx > {1'b0, LINE_MAX_OFF}) ? LINE_MAX_OFF : nx[OFF_W-1:0];
      case (scan_st)
        ST_CONTENT: begin
          if (c == CH_COMMA) begin
            empty_tail = 1'b1;
            close_field(1'b0);
            scan_st = ST_BEGIN;
          end else if (c == CH_BSLASH) begin
            scan_st = ST_ESC_O;
          end else if (!is_blank(c)) begin
            end_mark = p1;
          end
        end
        ST_QUOTE: begin
          if (c == CH_BSLASH) begin
            scan_st = ST_ESC_Q;
          end else if (c == CH_QUOTE) begin
            end_mark = p;
            scan_st  = ST_AFTER;
          end
        end
        ST_AFTER: begin
          if (c == CH_COMMA) begin
            empty_tail = 1'b1;
            close_field(1'b0);
            scan_st = ST_BEGIN;
          end
        end
        ST_ESC_Q: scan_st = ST_QUOTE;
        ST_ESC_O: scan_st = ST_CONTENT;
        default: begin
          if (c == CH_COMMA) begin
            start_mark = p;
            end_mark   = p;
            empty_tail = 1'b1;
            close_field(1'b0);
            scan_st = ST_BEGIN;
          end else if (is_blank(c)) begin
            scan_st = ST_BEGIN;
          end else if (c == CH_QUOTE) begin
            start_mark = p1;
            end_mark   = p1;
            scan_st    = ST_QUOTE;
          end else begin
            start_mark = p;
            end_mark   = p1;
            scan_st    = ST_CONTENT;
          end
        end
      endcase
      pos_cnt = p1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_fields.size() == 0) begin
      $error("unexpected field item: row %0d column %0d", out_mon.row, out_mon.column);
      mismatches++;
    end else begin
      want = expected_fields.pop_front();
      check_field("row", want.row, out_mon.row);
      check_field("column", 32'(want.column), 32'(out_mon.column));
      check_field("field_start", 32'(want.field_start), 32'(out_mon.field_start));
      check_field("field_end", 32'(want.field_end), 32'(out_mon.field_end));
      check_field("last_in_line", 32'(want.last_in_line), 32'(out_mon.last_in_line));
      check_field("too_long", 32'(want.too_long), 32'(out_mon.too_long));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_line();
      row_cnt = ROW_W'(1);
      expected_fields.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        scan_item(in_mon.ch, in_mon.line_end);
      end
    end
    outstanding = expected_fields.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Feeds directed lines, a few lines past the length limit and many random
// lines (mostly well-formed CSV, some noise and broken quoting) into the
// tokenizer, with random idle bursts on both channels. The checker beside
// the block predicts and compares every field item.
// ----------------------------------------------------------------------------

module tb_top;
  import cft_pkg::*;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  bit          idle_on = 1'b1;
  int unsigned sent    = 0;
  logic [7:0]  line_buf[$];

  always #5 clk_i = ~clk_i;

  cft_in_if  in_ch ();
  cft_out_if out_ch ();

  csv_field_tokenizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cft_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [7:0] c, input logic eol);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.ch       <= c;
    in_ch.line_end <= eol;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) push_item(line_buf[i], 1'b0);
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(33, 126));
    while (b == CH_COMMA || b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(33, 126));
    if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(128, 255));
    return b;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return CH_COMMA;
      1:       return CH_QUOTE;
      2:       return CH_BSLASH;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) line_buf.push_back(blank_byte());
  endtask

  task automatic add_field();
    int unsigned pick;
    add_blanks();
    case ($urandom_range(0, 3))
      0: ;
      1, 2: begin
        repeat ($urandom_range(1, 6)) begin
          pick = $urandom_range(0, 7);
          if (pick == 0) begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(any_byte());
          end else if (pick == 1) begin
            line_buf.push_back(blank_byte());
          end else begin
            line_buf.push_back(text_byte());
          end
        end
      end
      default: begin
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          pick = $urandom_range(0, 7);
          if (pick == 0) begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(any_byte());
          end else if (pick == 1) begin
            line_buf.push_back(CH_COMMA);
          end else if (pick == 2) begin
            line_buf.push_back(blank_byte());
          end else begin
            line_buf.push_back(text_byte());
          end
        end
        line_buf.push_back(CH_QUOTE);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) line_buf.push_back(text_byte());
        end
      end
    endcase
    add_blanks();
  endtask

  task automatic build_line();
    int unsigned mode;
    line_buf.delete();
    mode = $urandom_range(0, 19);
    if (mode < 17) begin
      add_field();
      repeat ($urandom_range(0, 5)) begin
        line_buf.push_back(CH_COMMA);
        add_field();
      end
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_COMMA);
    end else if (mode < 19) begin
      repeat ($urandom_range(0, 20)) line_buf.push_back(any_byte());
    end else begin
      add_field();
      line_buf.push_back(CH_COMMA);
      if ($urandom_range(0, 1)) begin
        line_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 4)) line_buf.push_back(text_byte());
        if ($urandom_range(0, 1)) line_buf.push_back(CH_BSLASH);
      end else begin
        repeat ($urandom_range(1, 4)) line_buf.push_back(text_byte());
        line_buf.push_back(CH_BSLASH);
      end
    end
  endtask

  initial begin
    int unsigned rand_start;
    in_ch.valid    = 1'b0;
    in_ch.ch       = 8'h00;
    in_ch.line_end = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Blanks, empty fields, quotes with escapes, text after a quote,
    // an escaped comma outside quotes and a trailing comma.
    line_buf.delete();
    put_text(" ab ,,\"q\\\"r\"z, c\\,d\t,");
    send_line();
    // An empty line yields no field.
    line_buf.delete();
    send_line();
    // A line that ends inside a quote after a backslash.
    line_buf.delete();
    put_text("\"a\\");
    send_line();
    // A line that ends right after a backslash outside quotes.
    line_buf.delete();
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_BSLASH);
    send_line();
    line_buf.delete();
    line_buf.push_back(8'h00);
    send_line();

    // Lines past the length limit: many commas, one very long field,
    // and mixed fields.
    line_buf.delete();
    repeat (LINE_MAX + 9) line_buf.push_back(CH_COMMA);
    send_line();
    line_buf.delete();
    repeat (LINE_MAX + 14) line_buf.push_back(text_byte());
    line_buf.push_back(CH_COMMA);
    line_buf.push_back(text_byte());
    send_line();
    line_buf.delete();
    while (line_buf.size() < LINE_MAX + 100) begin
      add_field();
      line_buf.push_back(CH_COMMA);
    end
    send_line();

    rand_start = sent;
    while (sent - rand_start < 1250) begin
      if (sent - rand_start > 1100) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 5) != 0);
      end
      build_line();
      send_line();
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cft_pkg.sv
rtl/cft_if.sv
rtl/cft_scan.sv
rtl/csv_field_tokenizer.sv
tb/cft_checker.sv
tb/tb_top.sv
